FILE: src/obde_pkg.sv
// Shared record codes and a helper function for the order book delta encoder.
package obde_pkg;

    typedef logic [3:0] t_kind;

    localparam t_kind KIND_FLAGS     = 4'd0;
    localparam t_kind KIND_REMOVED   = 4'd1;
    localparam t_kind KIND_CHANGED   = 4'd2;
    localparam t_kind KIND_INSERTED  = 4'd3;
    localparam t_kind KIND_TAIL      = 4'd4;
    localparam t_kind KIND_TAIL_LVL  = 4'd5;
    localparam t_kind KIND_SIDE_DONE = 4'd6;
    localparam t_kind KIND_LABEL     = 4'd7;
    localparam t_kind KIND_KEY_HDR   = 4'd8;
    localparam t_kind KIND_KEY_LVL   = 4'd9;
    localparam t_kind KIND_KEY_LABEL = 4'd10;

    localparam logic [16:0] KEYFRAME_RESET = 17'd4096;

    // Sign-extend the low 16 bits of a word.
    function automatic logic [31:0] sx16(input logic [31:0] v);
        return {{16{v[15]}}, v[15:0]};
    endfunction

endpackage

FILE: src/obde_if.sv
// Valid/ready channel interfaces for level items and result records.
interface obde_level_if;
    logic        valid;
    logic        ready;
    logic        is_bid;
    logic [31:0] price_level;
    logic [31:0] level_size;
    logic [31:0] order_count;
    logic [31:0] label;
    logic        row_end;

    modport source (output valid, is_bid, price_level, level_size, order_count, label, row_end,
                    input ready);
    modport sink (input valid, is_bid, price_level, level_size, order_count, label, row_end,
                  output ready);
endinterface

interface obde_rec_if;
    logic        valid;
    logic        ready;
    logic [3:0]  record_kind;
    logic [3:0]  skip_count;
    logic [31:0] price_value;
    logic [31:0] count_value;
    logic [31:0] size_value;
    logic [62:0] tick_value;
    logic        last_of_row;

    modport source (output valid, record_kind, skip_count, price_value, count_value,
                    size_value, tick_value, last_of_row, input ready);
    modport sink (input valid, record_kind, skip_count, price_value, count_value,
                  size_value, tick_value, last_of_row, output ready);
endinterface

FILE: src/order_book_delta_encoder_core.sv
// Top level of the order book delta encoder: level memory and row sequencer.
//
// Channel    Direction  Contents
// i_level    in         one book level item, row_end closes the row
// o_rec      out        one encoded record, last_of_row on the row's final record
// i_cfg_*    in         keyframe interval write
//
// A level item that does not close a row is taken while the sequencer is idle.
// The item that closes a row starts the sequencer, which holds i_level.ready low
// until done. A keyframe row passes through start, header, a read and an emit
// per level slot, and the label, then copies the row; a delta row compares the
// sides slot by slot, walks a merge per side (at most 2*LEVELS steps per side),
// and copies the row into the previous snapshot. The level memory is a single
// memory with two read ports. Reset is synchronous and clears the control
// state only. A stalled o_rec holds the sequencer in place; records are neither
// lost nor repeated.
module order_book_delta_encoder_core
    import obde_pkg::*;
#(
    parameter int LEVELS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    obde_level_if.sink  i_level,
    obde_rec_if.source  o_rec,
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_data
);

    localparam int SLOTS = 2 * LEVELS;
    localparam int AW = $clog2(4 * LEVELS);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int KW = $clog2(LEVELS + 1);

    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001,
        S_START = 16'h0002,
        S_SRD   = 16'h0004,
        S_SEX   = 16'h0008,
        S_FLAGS = 16'h0010,
        S_WRD   = 16'h0020,
        S_WEX   = 16'h0040,
        S_TRD   = 16'h0080,
        S_TEX   = 16'h0100,
        S_LABEL = 16'h0200,
        S_KHDR  = 16'h0400,
        S_KRD   = 16'h0800,
        S_KEX   = 16'h1000,
        S_KLBL  = 16'h2000,
        S_CRD   = 16'h4000,
        S_CWR   = 16'h8000
    } t_state;

    // The memory holds the current row at 0..SLOTS-1 and the previous row
    // above it, each entry packed as {price, size, count}.
    logic [95:0] r_mem [4 * LEVELS];
    logic [95:0] r_rd_a, r_rd_b;
    logic [AW-1:0] w_addr_a, w_addr_b;

    t_state      r_state, n_state;
    logic [SW-1:0] r_slot, n_slot;
    logic [SW-1:0] r_i, n_i;
    logic [KW-1:0] r_j, n_j, r_k, n_k;
    logic [3:0]  r_skip, n_skip;
    logic        r_side, n_side;
    logic        r_ask_diff, n_ask_diff, r_bid_diff, n_bid_diff;
    logic [31:0] r_last, n_last;
    logic [31:0] r_label, n_label;
    logic [62:0] r_row_index, n_row_index;
    logic [16:0] r_rows, n_rows;
    logic [16:0] r_ivl;

    logic        r_ov;
    logic [3:0]  r_kind;
    logic [3:0]  r_oskip;
    logic [31:0] r_oprice, r_ocount, r_osize;
    logic [62:0] r_otick;
    logic        r_olast;

    logic        e_en;
    t_kind       e_kind;
    logic [3:0]  e_skip;
    logic [31:0] e_price, e_count, e_size;
    logic [62:0] e_tick;
    logic        e_last;
    logic        can_emit;

    logic        w_accept;
    logic        w_we;
    logic [AW-1:0] w_waddr;
    logic [95:0] w_wdata;

    logic [31:0] pa, sa, ca, pb, sb, cb, ref_p;
    logic        asc;
    logic [17:0] rows_inc, ivl_eff;

    assign w_accept = i_level.valid && i_level.ready;
    assign i_level.ready = (r_state == S_IDLE);
    assign can_emit = !r_ov || o_rec.ready;

    assign pa = r_rd_a[95:64];
    assign sa = r_rd_a[63:32];
    assign ca = r_rd_a[31:0];
    assign pb = r_rd_b[95:64];
    assign sb = r_rd_b[63:32];
    assign cb = r_rd_b[31:0];
    assign asc = !r_side;

    // Read address selection follows the sequencer state.
    always_comb begin
        w_addr_a = AW'(r_i);
        w_addr_b = AW'(SLOTS + int'(r_i));
        case (r_state)
            S_WRD, S_WEX: begin
                w_addr_a = AW'(int'(r_side) * LEVELS + int'(r_k));
                w_addr_b = AW'(SLOTS + int'(r_side) * LEVELS + int'(r_j));
            end
            S_TRD, S_TEX: begin
                w_addr_a = AW'(int'(r_side) * LEVELS + int'(r_k));
                w_addr_b = AW'(SLOTS + int'(r_side) * LEVELS + LEVELS - 1);
            end
            default: ;
        endcase
    end

    assign w_we = w_accept || (r_state == S_CWR);
    assign w_waddr = (r_state == S_CWR) ? AW'(SLOTS + int'(r_i)) : AW'(r_slot);
    assign w_wdata = (r_state == S_CWR) ? r_rd_a :
        {i_level.price_level, i_level.level_size, i_level.order_count};

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_a <= r_mem[w_addr_a];
        r_rd_b <= r_mem[w_addr_b];
    end

    assign rows_inc = {1'b0, r_rows} + 18'd1;
    assign ivl_eff  = (r_ivl == 17'd0) ? 18'd1 : {1'b0, r_ivl};

    always_comb begin
        n_state = r_state;
        n_slot = r_slot;
        n_i = r_i;
        n_j = r_j;
        n_k = r_k;
        n_skip = r_skip;
        n_side = r_side;
        n_ask_diff = r_ask_diff;
        n_bid_diff = r_bid_diff;
        n_last = r_last;
        n_label = r_label;
        n_row_index = r_row_index;
        n_rows = r_rows;
        e_en = 1'b0;
        e_kind = KIND_FLAGS;
        e_skip = 4'd0;
        e_price = 32'd0;
        e_count = 32'd0;
        e_size = 32'd0;
        e_tick = 63'd0;
        e_last = 1'b0;
        ref_p = (r_k != '0) ? r_last : pb;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_level.row_end) begin
                        n_label = i_level.label;
                        n_state = S_START;
                    end else begin
                        n_slot = (r_slot == SW'(SLOTS - 1)) ? '0 : r_slot + 1'b1;
                    end
                end
            end
            S_START: begin
                n_i = '0;
                n_ask_diff = 1'b0;
                n_bid_diff = 1'b0;
                n_state = (r_rows == 17'd0) ? S_KHDR : S_SRD;
            end
            S_SRD: n_state = S_SEX;
            S_SEX: begin
                if (r_rd_a != r_rd_b) begin
                    if (int'(r_i) < LEVELS) begin
                        n_ask_diff = 1'b1;
                    end else begin
                        n_bid_diff = 1'b1;
                    end
                end
                if (r_i == SW'(SLOTS - 1)) begin
                    n_state = S_FLAGS;
                end else begin
                    n_i = r_i + 1'b1;
                    n_state = S_SRD;
                end
            end
            S_FLAGS: begin
                e_en = 1'b1;
                e_kind = KIND_FLAGS;
                e_count = {30'd0, r_bid_diff, r_ask_diff};
                if (can_emit) begin
                    n_j = '0;
                    n_k = '0;
                    n_skip = '0;
                    n_side = !r_ask_diff;
                    n_state = (r_ask_diff || r_bid_diff) ? S_WRD : S_LABEL;
                end
            end
            S_WRD: begin
                if (r_j != KW'(LEVELS) && r_k != KW'(LEVELS)) begin
                    n_state = S_WEX;
                end else begin
                    e_en = 1'b1;
                    if (r_k != KW'(LEVELS)) begin
                        e_kind = KIND_TAIL;
                        e_count = 32'(LEVELS) - 32'(r_k);
                        if (can_emit) n_state = S_TRD;
                    end else begin
                        e_kind = KIND_SIDE_DONE;
                        if (can_emit) begin
                            n_j = '0;
                            n_k = '0;
                            n_skip = '0;
                            n_side = 1'b1;
                            n_state = (!r_side && r_bid_diff) ? S_WRD : S_LABEL;
                        end
                    end
                end
            end
            S_WEX: begin
                if (pb == pa) begin
                    if (sa != sb || ca != cb) begin
                        e_en = 1'b1;
                        e_kind = KIND_CHANGED;
                        e_skip = r_skip;
                        e_count = sx16(ca - cb);
                        e_size = sx16(sa - sb);
                    end
                    if (can_emit || !e_en) begin
                        n_skip = e_en ? 4'd0 : r_skip + 4'd1;
                        n_j = r_j + 1'b1;
                        n_k = r_k + 1'b1;
                        n_last = pa;
                        n_state = S_WRD;
                    end
                end else if (($signed(pb) < $signed(pa)) == asc) begin
                    e_en = 1'b1;
                    e_kind = KIND_REMOVED;
                    e_skip = r_skip;
                    if (can_emit) begin
                        n_skip = '0;
                        n_j = r_j + 1'b1;
                        n_state = S_WRD;
                    end
                end else begin
                    e_en = 1'b1;
                    e_kind = KIND_INSERTED;
                    e_skip = r_skip;
                    e_price = asc ? ref_p - pa : pa - ref_p;
                    e_count = sx16(ca);
                    e_size = sx16(sa);
                    if (can_emit) begin
                        n_skip = '0;
                        n_k = r_k + 1'b1;
                        n_last = pa;
                        n_state = S_WRD;
                    end
                end
            end
            S_TRD: n_state = S_TEX;
            S_TEX: begin
                e_en = 1'b1;
                e_kind = KIND_TAIL_LVL;
                e_price = asc ? pa - ref_p : ref_p - pa;
                e_count = sx16(ca);
                e_size = sx16(sa);
                if (can_emit) begin
                    n_last = pa;
                    if (r_k == KW'(LEVELS - 1)) begin
                        n_j = '0;
                        n_k = '0;
                        n_skip = '0;
                        n_side = 1'b1;
                        n_state = (!r_side && r_bid_diff) ? S_WRD : S_LABEL;
                    end else begin
                        n_k = r_k + 1'b1;
                        n_state = S_TRD;
                    end
                end
            end
            S_LABEL: begin
                e_en = 1'b1;
                e_kind = KIND_LABEL;
                e_size = sx16(r_label);
                e_last = 1'b1;
                if (can_emit) begin
                    n_i = '0;
                    n_state = S_CRD;
                end
            end
            S_KHDR: begin
                e_en = 1'b1;
                e_kind = KIND_KEY_HDR;
                e_tick = r_row_index;
                if (can_emit) begin
                    n_i = '0;
                    n_state = S_KRD;
                end
            end
            S_KRD: n_state = S_KEX;
            S_KEX: begin
                e_en = 1'b1;
                e_kind = KIND_KEY_LVL;
                e_price = pa;
                e_count = ca;
                e_size = sa;
                if (can_emit) begin
                    if (r_i == SW'(SLOTS - 1)) begin
                        n_state = S_KLBL;
                    end else begin
                        n_i = r_i + 1'b1;
                        n_state = S_KRD;
                    end
                end
            end
            S_KLBL: begin
                e_en = 1'b1;
                e_kind = KIND_KEY_LABEL;
                e_size = r_label;
                e_last = 1'b1;
                if (can_emit) begin
                    n_i = '0;
                    n_state = S_CRD;
                end
            end
            S_CRD: n_state = S_CWR;
            S_CWR: begin
                if (r_i == SW'(SLOTS - 1)) begin
                    n_slot = '0;
                    n_row_index = r_row_index + 63'd1;
                    n_rows = (rows_inc >= ivl_eff) ? 17'd0 : rows_inc[16:0];
                    n_state = S_IDLE;
                end else begin
                    n_i = r_i + 1'b1;
                    n_state = S_CRD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_slot <= '0;
            r_row_index <= '0;
            r_rows <= '0;
            r_ivl <= KEYFRAME_RESET;
            r_ov <= 1'b0;
            r_i <= '0;
            r_j <= '0;
            r_k <= '0;
            r_skip <= '0;
            r_side <= 1'b0;
            r_ask_diff <= 1'b0;
            r_bid_diff <= 1'b0;
        end else begin
            r_state <= n_state;
            r_slot <= n_slot;
            r_row_index <= n_row_index;
            r_rows <= n_rows;
            r_i <= n_i;
            r_j <= n_j;
            r_k <= n_k;
            r_skip <= n_skip;
            r_side <= n_side;
            r_ask_diff <= n_ask_diff;
            r_bid_diff <= n_bid_diff;
            if (i_cfg_we) begin
                r_ivl <= i_cfg_data;
            end
            if (e_en && can_emit) begin
                r_ov <= 1'b1;
            end else if (o_rec.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_last <= n_last;
        r_label <= n_label;
        if (e_en && can_emit) begin
            r_kind <= e_kind;
            r_oskip <= e_skip;
            r_oprice <= e_price;
            r_ocount <= e_count;
            r_osize <= e_size;
            r_otick <= e_tick;
            r_olast <= e_last;
        end
    end

    assign o_rec.valid = r_ov;
    assign o_rec.record_kind = r_kind;
    assign o_rec.skip_count = r_oskip;
    assign o_rec.price_value = r_oprice;
    assign o_rec.count_value = r_ocount;
    assign o_rec.size_value = r_osize;
    assign o_rec.tick_value = r_otick;
    assign o_rec.last_of_row = r_olast;

endmodule

FILE: src/obde_chk.sv
// Port-level checker for the order book delta encoder, bound to the top level.
module obde_chk
    import obde_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [3:0] i_kind,
    input logic       i_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind) && $stable(i_last))
        else $error("stalled record changed");

    a_no_input_mid_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_last |-> !i_in_ready)
        else $error("input taken while a row is still being sent");

    a_label_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == KIND_LABEL || i_kind == KIND_KEY_LABEL) |-> i_last)
        else $error("label record not marked last");

    a_last_is_label: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_last |-> (i_kind == KIND_LABEL || i_kind == KIND_KEY_LABEL))
        else $error("row closed by a non-label record");

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("record valid after reset");

endmodule

bind order_book_delta_encoder_core obde_chk u_obde_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_ready (i_level.ready),
    .i_out_valid(o_rec.valid),
    .i_out_ready(o_rec.ready),
    .i_kind     (o_rec.record_kind),
    .i_last     (o_rec.last_of_row)
);
